// ===== design/npc_pkg.sv =====
package npc_pkg;

  // Default fraction width of the fixed-point coordinates.
  localparam int NPC_FRAC_BITS = 16;

  // Pipeline layout: three front stages, one divider stage per quotient bit, one output stage.
  localparam int NPC_FRONT_STAGES = 3;
  localparam int NPC_DIV_STEPS    = 32;
  localparam int NPC_STAGES       = NPC_FRONT_STAGES + NPC_DIV_STEPS + 1;

  // Division lanes: x and y of the cut on edge a-b, then x and y of the cut on edge a-c.
  localparam int NPC_LANES = 4;
  localparam int LANE_BX   = 0;
  localparam int LANE_BY   = 1;
  localparam int LANE_CX   = 2;
  localparam int LANE_CY   = 3;

  // Codes for the rotation start vertex.
  localparam logic [1:0] ROT_V0 = 2'd0;
  localparam logic [1:0] ROT_V1 = 2'd1;
  localparam logic [1:0] ROT_V2 = 2'd2;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  typedef struct packed {
    vtx_t p;
    vtx_t q;
    vtx_t r;
  } trg_t;

  // Rotated triangle and its clip case.
  typedef struct packed {
    vtx_t a;
    vtx_t b;
    vtx_t c;
    logic two;   // two vertices inside
    logic pass;  // all three inside
  } side_t;

  // Magnitudes ahead of the multiply.
  typedef struct packed {
    logic [31:0] m;
    logic [31:0] dmag;
    logic        neg;
  } pre_t;

  typedef struct packed {
    side_t             side;
    logic [31:0]       n;
    pre_t [NPC_LANES-1:0] lane;
  } pre_stage_t;

  // Restoring divider state: partial remainder, and a word that shifts the low
  // product bits out and the quotient bits in.
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] w;
    logic [31:0] m;
    logic        neg;
  } lane_t;

  typedef struct packed {
    side_t                 side;
    lane_t [NPC_LANES-1:0] lane;
  } div_t;

endpackage

// ===== design/npc_front.sv =====
module npc_front import npc_pkg::*; (
  input  logic         clk,
  input  logic [2:0]   en,
  input  logic [287:0] in_tdata,
  input  logic [30:0]  near,
  output logic         keep,
  output div_t         div_out
);

  vtx_t        v [3];
  logic [2:0]  ins;
  logic [2:0]  want;
  logic [1:0]  cnt;
  logic [1:0]  k;
  side_t       s1_nxt;
  side_t       s1_r;
  pre_stage_t  s2_nxt;
  pre_stage_t  s2_r;
  div_t        s3_nxt;
  div_t        s3_r;
  logic signed [33:0] num;

  // Unpack the three vertices, first field in the lowest bits.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v[i].x = in_tdata[96*i +: 32];
      v[i].y = in_tdata[96*i + 32 +: 32];
      v[i].z = in_tdata[96*i + 64 +: 32];
    end
  end

  // Classify each vertex against the plane and pick the rotation.
  always_comb begin
    logic signed [32:0] negz;
    for (int i = 0; i < 3; i++) begin
      negz   = 33'sd0 - {v[i].z[31], v[i].z};
      ins[i] = negz >= $signed({2'b00, near});
    end
    cnt  = 2'($countones(ins));
    keep = cnt != 2'd0;
    want = (cnt == 2'd1) ? ins : ~ins;
    priority if (want[0]) begin
      k = ROT_V0;
    end else if (want[1]) begin
      k = ROT_V1;
    end else begin
      k = ROT_V2;
    end
    s1_nxt.pass = cnt == 2'd3;
    s1_nxt.two  = cnt == 2'd2;
    unique case (k)
      ROT_V0: begin
        s1_nxt.a = v[0]; s1_nxt.b = v[1]; s1_nxt.c = v[2];
      end
      ROT_V1: begin
        s1_nxt.a = v[1]; s1_nxt.b = v[2]; s1_nxt.c = v[0];
      end
      default: begin
        s1_nxt.a = v[2]; s1_nxt.b = v[0]; s1_nxt.c = v[1];
      end
    endcase
    if (s1_nxt.pass) begin
      s1_nxt.a = v[0]; s1_nxt.b = v[1]; s1_nxt.c = v[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_r <= s1_nxt;
    end
  end

  // Differences and their magnitudes for both cut edges.
  always_comb begin
    logic signed [32:0] den;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    vtx_t o;
    num = 34'sd0 - $signed({3'b000, near}) - {{2{s1_r.a.z[31]}}, s1_r.a.z};
    s2_nxt.side = s1_r;
    s2_nxt.n    = num[33] ? 32'(34'sd0 - num) : num[31:0];
    for (int e = 0; e < 2; e++) begin
      o   = (e == 0) ? s1_r.b : s1_r.c;
      den = {o.z[31], o.z} - {s1_r.a.z[31], s1_r.a.z};
      dx  = {o.x[31], o.x} - {s1_r.a.x[31], s1_r.a.x};
      dy  = {o.y[31], o.y} - {s1_r.a.y[31], s1_r.a.y};
      s2_nxt.lane[2*e].m      = den[32] ? 32'(33'sd0 - den) : den[31:0];
      s2_nxt.lane[2*e+1].m    = s2_nxt.lane[2*e].m;
      s2_nxt.lane[2*e].neg    = dx[32];
      s2_nxt.lane[2*e].dmag   = dx[32] ? 32'(33'sd0 - dx) : dx[31:0];
      s2_nxt.lane[2*e+1].neg  = dy[32];
      s2_nxt.lane[2*e+1].dmag = dy[32] ? 32'(33'sd0 - dy) : dy[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_r <= s2_nxt;
    end
  end

  // Products; the high half seeds the divider remainder.
  always_comb begin
    logic [63:0] prod;
    s3_nxt.side = s2_r.side;
    for (int l = 0; l < NPC_LANES; l++) begin
      prod              = s2_r.n * s2_r.lane[l].dmag;
      s3_nxt.lane[l].rem = prod[63:32];
      s3_nxt.lane[l].w   = prod[31:0];
      s3_nxt.lane[l].m   = s2_r.lane[l].m;
      s3_nxt.lane[l].neg = s2_r.lane[l].neg;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_r <= s3_nxt;
    end
  end

  assign div_out = s3_r;

endmodule

// ===== design/npc_div_step.sv =====
module npc_div_step import npc_pkg::*; (
  input  logic clk,
  input  logic en,
  input  div_t d_in,
  output div_t d_out
);

  div_t d_nxt;
  div_t d_r;

  // One restoring step per lane: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    logic [32:0] t;
    logic [32:0] diff;
    logic        ge;
    d_nxt.side = d_in.side;
    for (int l = 0; l < NPC_LANES; l++) begin
      t    = {d_in.lane[l].rem, d_in.lane[l].w[31]};
      diff = t - {1'b0, d_in.lane[l].m};
      ge   = t >= {1'b0, d_in.lane[l].m};
      d_nxt.lane[l].rem = ge ? diff[31:0] : t[31:0];
      d_nxt.lane[l].w   = {d_in.lane[l].w[30:0], ge};
      d_nxt.lane[l].m   = d_in.lane[l].m;
      d_nxt.lane[l].neg = d_in.lane[l].neg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

// ===== design/npc_back.sv =====
module npc_back import npc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [30:0]  near,
  input  div_t         d_in,
  output logic         done,
  output logic [287:0] out_tdata,
  output logic         out_tlast
);

  trg_t t0_nxt;
  trg_t t1_nxt;
  trg_t t0_r;
  trg_t t1_r;
  trg_t cur;
  logic two_r;
  logic piece_r;
  logic piece_nxt;
  vtx_t ib;
  vtx_t ic;
  side_t s;

  // Apply the signed offsets to get both cut points, then build the triangles.
  always_comb begin
    logic [31:0] q [NPC_LANES];
    coord_t      nz;
    s  = d_in.side;
    for (int l = 0; l < NPC_LANES; l++) begin
      q[l] = d_in.lane[l].w;
    end
    nz   = 32'd0 - {1'b0, near};
    ib.x = d_in.lane[LANE_BX].neg ? s.a.x - q[LANE_BX] : s.a.x + q[LANE_BX];
    ib.y = d_in.lane[LANE_BY].neg ? s.a.y - q[LANE_BY] : s.a.y + q[LANE_BY];
    ib.z = nz;
    ic.x = d_in.lane[LANE_CX].neg ? s.a.x - q[LANE_CX] : s.a.x + q[LANE_CX];
    ic.y = d_in.lane[LANE_CY].neg ? s.a.y - q[LANE_CY] : s.a.y + q[LANE_CY];
    ic.z = nz;
    t1_nxt.p = ic;
    t1_nxt.q = s.b;
    t1_nxt.r = s.c;
    priority if (s.pass) begin
      t0_nxt.p = s.a; t0_nxt.q = s.b; t0_nxt.r = s.c;
    end else if (s.two) begin
      t0_nxt.p = ib; t0_nxt.q = s.b; t0_nxt.r = ic;
    end else begin
      t0_nxt.p = s.a; t0_nxt.q = ib; t0_nxt.r = ic;
    end
  end

  // The held item leaves once its final piece is taken.
  assign done = out_tvalid && out_tready && (!two_r || piece_r);

  always_comb begin
    piece_nxt = piece_r;
    if (en) begin
      piece_nxt = 1'b0;
    end else if (out_tvalid && out_tready && two_r && !piece_r) begin
      piece_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      piece_r <= 1'b0;
    end else begin
      piece_r <= piece_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r  <= t0_nxt;
      t1_r  <= t1_nxt;
      two_r <= s.two && !s.pass;
    end
  end

  // Present the current piece, first field in the lowest bits.
  assign cur       = piece_r ? t1_r : t0_r;
  assign out_tdata = {cur.r.z, cur.r.y, cur.r.x, cur.q.z, cur.q.y, cur.q.x,
                      cur.p.z, cur.p.y, cur.p.x};
  assign out_tlast = !two_r || piece_r;

endmodule

// ===== design/near_plane_triangle_clipper.sv =====
// Near-plane triangle clipper, fully pipelined over 36 register stages.
// An accepted triangle passes the front, divider and output stages in turn before its first result transaction.
// Throughput: one triangle per cycle when it yields one piece and out_tready holds; a triangle
// that yields two pieces holds the single result port, and the pipeline behind it, until both are taken.
// Reset: synchronous active-low rst_n clears all valid bits and the piece counter,
// and loads the near distance with 0.1 in the configured fixed-point format.
module near_plane_triangle_clipper import npc_pkg::*; #(
  parameter int FRAC_BITS = NPC_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [287:0] in_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [287:0] out_tdata,  // p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z
  output logic         out_tlast,  // last_piece
  input  logic         cfg_wr_en,
  input  logic [30:0]  cfg_wr_data
);

  localparam logic [30:0] NEAR_RST = 31'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

  logic [30:0]           near_r;
  logic [NPC_STAGES-1:0] v_r;
  logic [NPC_STAGES-1:0] en;
  logic                  keep;
  logic                  done;
  div_t                  dv [NPC_DIV_STEPS+1];

  // Near distance register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= NEAR_RST;
    end else if (cfg_wr_en) begin
      near_r <= cfg_wr_data;
    end
  end

  // A stage loads when it is empty or its contents move on.
  assign en[NPC_STAGES-1] = !v_r[NPC_STAGES-1] || done;
  for (genvar i = 0; i < NPC_STAGES - 1; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NPC_STAGES-1];

  // Valid bits; a triangle fully outside is dropped at entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid && keep;
      end
      for (int i = 1; i < NPC_STAGES; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  npc_front u_front (
    .clk      (clk),
    .en       (en[NPC_FRONT_STAGES-1:0]),
    .in_tdata (in_tdata),
    .near     (near_r),
    .keep     (keep),
    .div_out  (dv[0])
  );

  for (genvar s = 0; s < NPC_DIV_STEPS; s++) begin : g_div
    npc_div_step u_step (
      .clk   (clk),
      .en    (en[NPC_FRONT_STAGES+s]),
      .d_in  (dv[s]),
      .d_out (dv[s+1])
    );
  end

  npc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en[NPC_STAGES-1]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .near       (near_r),
    .d_in       (dv[NPC_DIV_STEPS]),
    .done       (done),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // An empty pipeline always takes a transaction.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r == '0) |-> in_tready)
    else $error("empty pipeline not ready");

  // The first piece of a pair is always followed by the second.
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> (out_tvalid && out_tlast))
    else $error("second piece missing");

  // Nothing is presented right after reset.
  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid after reset");

endmodule
